@@ rtl/core/lept_pkg.sv @@
// Shared types and constants for the lane edge point tracker.
package lept_pkg;

    localparam int ROW_W = 9;
    localparam int COL_W = 10;
    localparam int PIX_W = 8;
    localparam int DZ_W  = 9;
    localparam int TOL_W = 10;

    localparam logic [PIX_W-1:0] LINE_PIXEL = 8'd255;

    localparam logic [DZ_W-1:0]  DEADZONE_RESET  = 9'd10;
    localparam logic [TOL_W-1:0] TOLERANCE_RESET = 10'd20;

    // register index, taken from paddr[2]
    localparam logic REG_DEADZONE  = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;

    localparam logic SIDE_RIGHT = 1'b0;
    localparam logic SIDE_LEFT  = 1'b1;

    // classified pixel word handed from front to back
    typedef struct packed {
        logic [COL_W-1:0] column;
        logic             right_ok;
        logic             left_ok;
        logic             frame_end;
    } lept_class_t;

    typedef struct packed {
        logic [DZ_W-1:0]  deadzone;
        logic [TOL_W-1:0] tolerance;
    } lept_cfg_t;

    typedef struct packed {
        logic             side;
        logic             bottom_found;
        logic             line_valid;
        logic [COL_W-1:0] bottom_x;
        logic [ROW_W-1:0] bottom_y;
        logic [COL_W-1:0] top_x;
        logic [ROW_W-1:0] top_y;
        logic             last_of_frame;
    } lept_result_t;

endpackage

@@ rtl/core/lept_front.sv @@
// Front end: accepts pixels, matches scan rows and range-checks edge candidates.
module lept_front #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480,
    parameter int NUM_POINTS   = 8,
    parameter int ROW_OFFSET   = 0,
    parameter int ROW_DIVISOR  = 2
) (
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [lept_pkg::ROW_W-1:0] row_index,
    input  logic [lept_pkg::COL_W-1:0] column_index,
    input  logic [lept_pkg::PIX_W-1:0] pixel_value,
    input  logic                      frame_end,
    input  lept_pkg::lept_cfg_t       cfg,
    input  logic                      q_full,
    output logic                      push,
    output lept_pkg::lept_class_t     push_class,
    output logic [NUM_POINTS-1:0]     push_mask
);
    import lept_pkg::*;

    localparam int CENTRE = FRAME_WIDTH / 2;

    logic [31:0] col_ext;
    logic [31:0] row_ext;
    logic [31:0] dz_ext;
    logic        is_line;

    assign col_ext = {{(32-COL_W){1'b0}}, column_index};
    assign row_ext = {{(32-ROW_W){1'b0}}, row_index};
    assign dz_ext  = {{(32-DZ_W){1'b0}}, cfg.deadzone};
    assign is_line = (pixel_value == LINE_PIXEL);

    genvar g;
    generate
        for (g = 0; g < NUM_POINTS; g++)
        begin : g_rows
            localparam int SCAN_ROW =
                ((NUM_POINTS - g + ROW_OFFSET) * FRAME_HEIGHT) / (ROW_DIVISOR * NUM_POINTS);
            assign push_mask[g] = is_line && (row_ext == 32'(SCAN_ROW));
        end
    endgenerate

    always_comb
    begin
        push_class.column    = column_index;
        push_class.right_ok  = is_line && (col_ext >= 32'(CENTRE))
                               && ((col_ext + dz_ext) < 32'(FRAME_WIDTH));
        push_class.left_ok   = is_line && (col_ext <= 32'(CENTRE)) && (col_ext > dz_ext);
        push_class.frame_end = frame_end;
    end

    assign in_ready = !q_full;
    // drop background pixels that carry no frame end
    assign push = in_valid && !q_full && (is_line || frame_end);

endmodule

@@ rtl/core/lept_queue.sv @@
// Four-entry word queue between front and back.
module lept_queue #(
    parameter int WIDTH = 21
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    import lept_pkg::*;

    localparam int DEPTH = 4;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [1:0]       wr_ptr_reg;
    logic [1:0]       rd_ptr_reg;
    logic [2:0]       count_reg;
    logic [2:0]       count_next;

    assign full      = (count_reg == 3'(DEPTH));
    assign not_empty = (count_reg != 3'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/lept_back.sv @@
// Back end: edge store update, per-side line walk and result register.
module lept_back #(
    parameter int FRAME_HEIGHT = 480,
    parameter int NUM_POINTS   = 8,
    parameter int ROW_OFFSET   = 0,
    parameter int ROW_DIVISOR  = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lept_pkg::lept_cfg_t    cfg,
    input  logic                   q_not_empty,
    input  lept_pkg::lept_class_t  q_class,
    input  logic [NUM_POINTS-1:0]  q_mask,
    output logic                   pop,
    output logic                   res_valid,
    input  logic                   res_ready,
    output lept_pkg::lept_result_t res
);
    import lept_pkg::*;

    localparam int IDX_W = $clog2(NUM_POINTS);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [ROW_W-1:0] scan_tbl [NUM_POINTS];

    genvar g;
    generate
        for (g = 0; g < NUM_POINTS; g++)
        begin : g_rows
            localparam int SCAN_ROW =
                ((NUM_POINTS - g + ROW_OFFSET) * FRAME_HEIGHT) / (ROW_DIVISOR * NUM_POINTS);
            assign scan_tbl[g] = ROW_W'(SCAN_ROW);
        end
    endgenerate

    logic [COL_W-1:0] right_col_reg [NUM_POINTS];
    logic [COL_W-1:0] left_col_reg  [NUM_POINTS];
    logic [NUM_POINTS-1:0] right_seen_reg;
    logic [NUM_POINTS-1:0] left_seen_reg;
    logic [NUM_POINTS-1:0] upd_right;
    logic [NUM_POINTS-1:0] upd_left;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             side_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             bot_reg;
    logic             valid_reg;
    logic             stop_reg;
    logic [COL_W-1:0] prev_reg;
    logic [COL_W-1:0] bx_reg;
    logic [ROW_W-1:0] by_reg;
    logic [COL_W-1:0] tx_reg;
    logic [ROW_W-1:0] ty_reg;

    logic             out_valid_reg;
    lept_result_t     out_reg;

    logic             clear_store;
    logic             load_out;
    logic             cur_seen;
    logic [COL_W-1:0] cur_col;
    logic [COL_W-1:0] step;
    logic             take_bot;
    logic             take_top;
    logic             hit_stop;
    logic             last_idx;

    assign pop = (state_reg == ST_RUN) && q_not_empty;

    always_comb
    begin
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            upd_right[i] = pop && q_mask[i] && q_class.right_ok
                           && (!right_seen_reg[i] || (q_class.column < right_col_reg[i]));
            upd_left[i]  = pop && q_mask[i] && q_class.left_ok
                           && (!left_seen_reg[i] || (q_class.column > left_col_reg[i]));
        end
    end

    // walk datapath: one scan row per cycle, bottom row first
    assign cur_seen = side_reg ? left_seen_reg[idx_reg] : right_seen_reg[idx_reg];
    assign cur_col  = side_reg ? left_col_reg[idx_reg]  : right_col_reg[idx_reg];
    assign step     = (cur_col > prev_reg) ? (cur_col - prev_reg) : (prev_reg - cur_col);
    assign take_bot = (state_reg == ST_WALK) && !stop_reg && cur_seen && !bot_reg;
    assign take_top = (state_reg == ST_WALK) && !stop_reg && cur_seen && bot_reg
                      && (step < cfg.tolerance);
    assign hit_stop = (state_reg == ST_WALK) && !stop_reg && cur_seen && bot_reg
                      && (step >= cfg.tolerance);
    assign last_idx = (idx_reg == IDX_W'(NUM_POINTS - 1));

    assign load_out    = (state_reg == ST_EMIT) && (!out_valid_reg || res_ready);
    assign clear_store = load_out && (side_reg == SIDE_LEFT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (pop && q_class.frame_end)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (last_idx)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = (side_reg == SIDE_LEFT) ? ST_RUN : ST_WALK;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            side_reg       <= SIDE_RIGHT;
            idx_reg        <= '0;
            bot_reg        <= 1'b0;
            valid_reg      <= 1'b0;
            stop_reg       <= 1'b0;
            right_seen_reg <= '0;
            left_seen_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_store)
            begin
                right_seen_reg <= '0;
                left_seen_reg  <= '0;
            end
            else
            begin
                right_seen_reg <= right_seen_reg | upd_right;
                left_seen_reg  <= left_seen_reg | upd_left;
            end

            if (pop && q_class.frame_end)
            begin
                side_reg  <= SIDE_RIGHT;
                idx_reg   <= '0;
                bot_reg   <= 1'b0;
                valid_reg <= 1'b0;
                stop_reg  <= 1'b0;
            end
            else if (state_reg == ST_WALK)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (take_bot)
                begin
                    bot_reg <= 1'b1;
                end
                if (take_top)
                begin
                    valid_reg <= 1'b1;
                end
                if (hit_stop)
                begin
                    stop_reg <= 1'b1;
                end
            end
            else if (load_out)
            begin
                // advance to the left side
                side_reg  <= SIDE_LEFT;
                idx_reg   <= '0;
                bot_reg   <= 1'b0;
                valid_reg <= 1'b0;
                stop_reg  <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            if (upd_right[i])
            begin
                right_col_reg[i] <= q_class.column;
            end
            if (upd_left[i])
            begin
                left_col_reg[i] <= q_class.column;
            end
        end

        if (take_bot)
        begin
            bx_reg   <= cur_col;
            by_reg   <= scan_tbl[idx_reg];
            prev_reg <= cur_col;
        end
        if (take_top)
        begin
            tx_reg   <= cur_col;
            ty_reg   <= scan_tbl[idx_reg];
            prev_reg <= cur_col;
        end

        if (load_out)
        begin
            out_reg.side          <= side_reg;
            out_reg.bottom_found  <= bot_reg;
            out_reg.line_valid    <= valid_reg;
            out_reg.bottom_x      <= bot_reg ? bx_reg : '0;
            out_reg.bottom_y      <= bot_reg ? by_reg : '0;
            out_reg.top_x         <= valid_reg ? tx_reg : '0;
            out_reg.top_y         <= valid_reg ? ty_reg : '0;
            out_reg.last_of_frame <= side_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

@@ rtl/core/lane_edge_point_tracker.sv @@
// Top level of the lane edge point tracker: APB registers, front, queue and back.
// Pixels: one word per cycle while the queue is not full; a word kept by the front is written into the queue and
// reaches the edge store when the back pops it. Frame end: the back walks NUM_POINTS rows per side, one row a
// cycle; each result is loaded into the output register from the emit state once that register is free, the
// right side first, then the left side. Pixels keep flowing into the 4-word queue during the walk until it is full.
// Reset (rst_n low, asynchronous): queue and edge store empty, no result pending,
// edge_deadzone = 10, step_tolerance = 20.
module lane_edge_point_tracker #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480,
    parameter int NUM_POINTS   = 8,
    parameter int ROW_OFFSET   = 0,
    parameter int ROW_DIVISOR  = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row_index[8:0], column_index[18:9], pixel_value[26:19]
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // bottom_found[0], line_valid[1], bottom_x[11:2],
                                   // bottom_y[20:12], top_x[30:21], top_y[39:31]
    output logic [0:0]  m_tuser,   // side[0]
    output logic        m_tlast,   // last_of_frame
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lept_pkg::*;

    localparam int QW = $bits(lept_class_t) + NUM_POINTS;

    logic [DZ_W-1:0]  deadzone_reg;
    logic [TOL_W-1:0] tolerance_reg;
    lept_cfg_t        cfg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg  <= DEADZONE_RESET;
            tolerance_reg <= TOLERANCE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_DEADZONE:  deadzone_reg  <= pwdata[DZ_W-1:0];
                REG_TOLERANCE: tolerance_reg <= pwdata[TOL_W-1:0];
                default:       deadzone_reg  <= deadzone_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DEADZONE:  prdata = {{(32-DZ_W){1'b0}}, deadzone_reg};
            REG_TOLERANCE: prdata = {{(32-TOL_W){1'b0}}, tolerance_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.deadzone  = deadzone_reg;
    assign cfg.tolerance = tolerance_reg;

    logic                  push;
    lept_class_t           push_class;
    logic [NUM_POINTS-1:0] push_mask;
    logic                  q_full;
    logic                  q_not_empty;
    logic                  pop;
    logic [QW-1:0]         q_data;
    lept_class_t           q_class;
    logic [NUM_POINTS-1:0] q_mask;
    logic                  res_valid;
    lept_result_t          res;

    lept_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .NUM_POINTS   (NUM_POINTS),
        .ROW_OFFSET   (ROW_OFFSET),
        .ROW_DIVISOR  (ROW_DIVISOR)
    ) u_front (
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .row_index    (s_tdata[8:0]),
        .column_index (s_tdata[18:9]),
        .pixel_value  (s_tdata[26:19]),
        .frame_end    (s_tlast),
        .cfg          (cfg),
        .q_full       (q_full),
        .push         (push),
        .push_class   (push_class),
        .push_mask    (push_mask)
    );

    lept_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_mask, push_class}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    assign q_class = q_data[$bits(lept_class_t)-1:0];
    assign q_mask  = q_data[QW-1:$bits(lept_class_t)];

    lept_back #(
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .NUM_POINTS   (NUM_POINTS),
        .ROW_OFFSET   (ROW_OFFSET),
        .ROW_DIVISOR  (ROW_DIVISOR)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_class     (q_class),
        .q_mask      (q_mask),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tvalid   = res_valid;
    assign m_tdata    = {res.top_y, res.top_x, res.bottom_y, res.bottom_x,
                         res.line_valid, res.bottom_found};
    assign m_tuser[0] = res.side;
    assign m_tlast    = res.last_of_frame;

endmodule

@@ rtl/core/lept_checker.sv @@
// Port-level checks on the result stream of the lane edge point tracker.
module lept_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);
    import lept_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // the left-side result closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == m_tuser[0]))
        else $error("last_of_frame does not follow side");

    // no bottom point means no line and a zero bottom point
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> !m_tdata[1] && (m_tdata[20:2] == 19'd0))
        else $error("bottom fields set without bottom point");

    // no line means a zero top point
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> (m_tdata[39:21] == 19'd0))
        else $error("top fields set without valid line");

endmodule

bind lane_edge_point_tracker lept_checker u_lept_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/lane_edge_point_tracker_test.sv @@
// Stream testbench for the lane edge point tracker: directed and random frames checked against a line predictor.
module lane_edge_point_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lept_pkg::*;

    localparam int FRAME_WIDTH   = 640;
    localparam int FRAME_HEIGHT  = 480;
    localparam int NUM_POINTS    = 8;
    localparam int ROW_OFFSET    = 0;
    localparam int ROW_DIVISOR   = 2;
    localparam int CENTRE        = FRAME_WIDTH / 2;
    localparam int SETTLE_CYCLES = 2 * NUM_POINTS + 24;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 145;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } pixel_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;    // row_index[8:0], column_index[18:9], pixel_value[26:19]
    logic        s_tlast = 1'b0;  // frame_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // bottom_found[0], line_valid[1], bottom_x[11:2],
                                  // bottom_y[20:12], top_x[30:21], top_y[39:31]
    logic [0:0]  m_tuser;         // side[0]
    logic        m_tlast;         // last_of_frame
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pixel_word_t  pending_pixels [$];
    lept_result_t line_results [$];
    pixel_word_t  word_on_bus;

    // tracked copy of the edge store and registers
    bit [COL_W-1:0] right_column [NUM_POINTS];
    bit             right_seen   [NUM_POINTS];
    bit [COL_W-1:0] left_column  [NUM_POINTS];
    bit             left_seen    [NUM_POINTS];
    bit [DZ_W-1:0]  deadzone_setting  = DEADZONE_RESET;
    bit [TOL_W-1:0] tolerance_setting = TOLERANCE_RESET;

    int send_gap = 0;
    int send_burst = 0;
    int sink_stall = 0;
    int sink_burst = 0;
    int mismatch_count = 0;
    int pixels_taken = 0;
    int lines_checked = 0;
    int frames_queued = 0;
    int settings_used = 1;
    int cycle_count = 0;

    lane_edge_point_tracker #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .FRAME_HEIGHT(FRAME_HEIGHT),
        .NUM_POINTS  (NUM_POINTS),
        .ROW_OFFSET  (ROW_OFFSET),
        .ROW_DIVISOR (ROW_DIVISOR)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    function automatic int scan_row_of(int i);
        return ((NUM_POINTS - i + ROW_OFFSET) * FRAME_HEIGHT) / (ROW_DIVISOR * NUM_POINTS);
    endfunction

    // Mostly short gaps, a few long ones, and now and then a burst with none.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst = $urandom_range(20, 80);
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic lept_result_t walk_line(logic side, logic last);
        lept_result_t line;
        int unsigned prev;
        int unsigned c;
        int unsigned step;
        bit seen;
        line = '0;
        line.side = side;
        line.last_of_frame = last;
        prev = 0;
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            seen = (side == SIDE_RIGHT) ? right_seen[i] : left_seen[i];
            c = (side == SIDE_RIGHT) ? right_column[i] : left_column[i];
            if (!seen)
            begin
                continue;
            end
            if (!line.bottom_found)
            begin
                line.bottom_found = 1'b1;
                line.bottom_x = COL_W'(c);
                line.bottom_y = ROW_W'(scan_row_of(i));
                prev = c;
                continue;
            end
            // measure from the last accepted point, not the row below
            step = (c > prev) ? c - prev : prev - c;
            if (step < tolerance_setting)
            begin
                line.line_valid = 1'b1;
                line.top_x = COL_W'(c);
                line.top_y = ROW_W'(scan_row_of(i));
                prev = c;
            end
            else
            begin
                break;
            end
        end
        return line;
    endfunction

    task automatic track_pixel(pixel_word_t w);
        int unsigned col;
        bit right_ok;
        bit left_ok;
        col = w.column;
        if (w.pixel == LINE_PIXEL)
        begin
            right_ok = col >= CENTRE && col + deadzone_setting < FRAME_WIDTH;
            left_ok  = col <= CENTRE && col > deadzone_setting;
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                if (scan_row_of(i) != w.row)
                begin
                    continue;
                end
                // keep the column nearest the centre
                if (right_ok && (!right_seen[i] || col < right_column[i]))
                begin
                    right_seen[i] = 1'b1;
                    right_column[i] = COL_W'(col);
                end
                if (left_ok && (!left_seen[i] || col > left_column[i]))
                begin
                    left_seen[i] = 1'b1;
                    left_column[i] = COL_W'(col);
                end
            end
        end
        if (w.frame_end)
        begin
            line_results.push_back(walk_line(SIDE_RIGHT, 1'b0));
            line_results.push_back(walk_line(SIDE_LEFT, 1'b1));
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                right_seen[i] = 1'b0;
                right_column[i] = '0;
                left_seen[i] = 1'b0;
                left_column[i] = '0;
            end
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic push_word(int row, int col, int pix, bit fend);
        pixel_word_t w;
        w.row = ROW_W'(row);
        w.column = COL_W'(col);
        w.pixel = PIX_W'(pix);
        w.frame_end = fend;
        pending_pixels.push_back(w);
    endtask

    // One frame: two drifting lines over the scan rows plus some background and noise.
    task automatic queue_frame(int count);
        int right_line [NUM_POINTS];
        int left_line  [NUM_POINTS];
        int cap;
        int d;
        int c;
        int r;
        int i;
        pixel_word_t w;
        cap = (tolerance_setting < 40) ? int'(tolerance_setting) + 3 : 40;
        right_line[0] = $urandom_range(CENTRE, FRAME_WIDTH - 1);
        left_line[0]  = $urandom_range(0, CENTRE);
        for (int k = 1; k < NUM_POINTS; k++)
        begin
            d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 200) : $urandom_range(0, cap);
            c = right_line[k-1] + ($urandom_range(0, 1) ? d : -d);
            right_line[k] = (c < CENTRE) ? CENTRE : (c > FRAME_WIDTH - 1) ? FRAME_WIDTH - 1 : c;
            d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 200) : $urandom_range(0, cap);
            c = left_line[k-1] + ($urandom_range(0, 1) ? d : -d);
            left_line[k] = (c < 0) ? 0 : (c > CENTRE) ? CENTRE : c;
        end
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            i = $urandom_range(0, NUM_POINTS - 1);
            w.row = ROW_W'(scan_row_of(i));
            w.pixel = LINE_PIXEL;
            w.frame_end = (k == count - 1);
            if (r < 40)
            begin
                d = $urandom_range(0, 4);
                c = right_line[i] + d;
                w.column = COL_W'((c > FRAME_WIDTH - 1) ? FRAME_WIDTH - 1 : c);
            end
            else if (r < 80)
            begin
                d = $urandom_range(0, 4);
                c = left_line[i] - d;
                w.column = COL_W'((c < 0) ? 0 : c);
            end
            else if (r < 88)
            begin
                w.column = COL_W'($urandom_range(0, FRAME_WIDTH - 1));
                w.pixel = PIX_W'($urandom_range(0, 254));
            end
            else if (r < 96)
            begin
                w.row = ROW_W'($urandom_range(0, FRAME_HEIGHT - 1));
                w.column = COL_W'($urandom_range(0, FRAME_WIDTH - 1));
                w.pixel = $urandom_range(0, 1) ? LINE_PIXEL : PIX_W'($urandom_range(0, 255));
            end
            else
            begin
                w.row = ROW_W'($urandom_range(0, 511));
                w.column = COL_W'($urandom_range(0, 1023));
                w.pixel = PIX_W'($urandom_range(0, 255));
            end
            pending_pixels.push_back(w);
        end
        frames_queued++;
    endtask

    task automatic queue_random(int items);
        int queued;
        int len;
        queued = 0;
        while (queued < items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 24);
            queue_frame(len);
            queued += len;
        end
    endtask

    task automatic write_register(logic reg_sel, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_DEADZONE)
        begin
            deadzone_setting = value[DZ_W-1:0];
        end
        else
        begin
            tolerance_setting = value[TOL_W-1:0];
        end
    endtask

    // Hold until every word is taken, every line result is back and the back end is quiet.
    // Sample at the falling edge so the driver's last update has settled.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_pixels.size() > 0 || s_tvalid || line_results.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : pixel_driver
        pixel_word_t w;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                track_pixel(word_on_bus);
                pixels_taken++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_pixels.size() > 0)
                begin
                    w = pending_pixels.pop_front();
                    word_on_bus = w;
                    s_tdata  <= {5'd0, w.pixel, w.column, w.row};
                    s_tlast  <= w.frame_end;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap(send_burst);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_sink
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ((m_tvalid && m_tready) || $urandom_range(0, 15) == 0)
            begin
                sink_stall = pick_gap(sink_burst);
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        lept_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (line_results.size() == 0)
            begin
                $error("line result with none expected: side %0d", m_tuser[0]);
                mismatch_count++;
            end
            else
            begin
                want = line_results.pop_front();
                check_field("side", want.side, m_tuser[0]);
                check_field("bottom_found", want.bottom_found, m_tdata[0]);
                check_field("line_valid", want.line_valid, m_tdata[1]);
                check_field("bottom_x", want.bottom_x, m_tdata[11:2]);
                check_field("bottom_y", want.bottom_y, m_tdata[20:12]);
                check_field("top_x", want.top_x, m_tdata[30:21]);
                check_field("top_y", want.top_y, m_tdata[39:31]);
                check_field("last_of_frame", want.last_of_frame, m_tlast);
                lines_checked++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int dz;
        int tol;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty frame: nothing found on either side
        push_word(0, 0, 0, 1'b1);
        // centre pixel, deadzone borders, background value, rows off the scan grid
        push_word(240, CENTRE, LINE_PIXEL, 1'b0);
        push_word(240, 400, LINE_PIXEL, 1'b0);
        push_word(210, 630, LINE_PIXEL, 1'b0);
        push_word(210, 629, LINE_PIXEL, 1'b0);
        push_word(210, 10, LINE_PIXEL, 1'b0);
        push_word(210, 11, LINE_PIXEL, 1'b0);
        push_word(180, 335, 254, 1'b0);
        push_word(180, 335, LINE_PIXEL, 1'b0);
        push_word(479, 639, LINE_PIXEL, 1'b0);
        push_word(0, 0, LINE_PIXEL, 1'b0);
        push_word(511, 1023, LINE_PIXEL, 1'b0);
        push_word(150, 300, LINE_PIXEL, 1'b1);
        // steady lines out of raster order, rows missing, left line broken by a jump
        push_word(30, 420, LINE_PIXEL, 1'b0);
        push_word(240, 400, LINE_PIXEL, 1'b0);
        push_word(180, 408, LINE_PIXEL, 1'b0);
        push_word(210, 404, LINE_PIXEL, 1'b0);
        push_word(120, 415, LINE_PIXEL, 1'b0);
        push_word(240, 250, LINE_PIXEL, 1'b0);
        push_word(210, 245, LINE_PIXEL, 1'b0);
        push_word(180, 200, LINE_PIXEL, 1'b0);
        push_word(150, 198, LINE_PIXEL, 1'b0);
        push_word(90, 196, LINE_PIXEL, 1'b1);
        frames_queued += 3;

        queue_random(150);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    dz = 0;
                    tol = 0;
                end
                1:
                begin
                    dz = 319;
                    tol = 639;
                end
                2:
                begin
                    dz = 0;
                    tol = 1023;
                end
                3:
                begin
                    dz = 511;
                    tol = 1;
                end
                4:
                begin
                    dz = 319;
                    tol = 20;
                end
                default:
                begin
                    dz = $urandom_range(0, 319);
                    tol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 639)
                                                      : $urandom_range(1, 60);
                end
            endcase
            write_register(REG_DEADZONE, dz);
            write_register(REG_TOLERANCE, tol);
            settings_used++;
            queue_random(PHASE_ITEMS);
        end

        wait_idle();
        $display("%0d pixel words in %0d frames, %0d line results checked",
                 pixels_taken, frames_queued, lines_checked);
        $display("deadzone and step tolerance swept over %0d settings, extremes included",
                 settings_used);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ lane_edge_point_tracker.f @@
rtl/core/lept_pkg.sv
rtl/core/lept_front.sv
rtl/core/lept_queue.sv
rtl/core/lept_back.sv
rtl/core/lane_edge_point_tracker.sv
rtl/core/lept_checker.sv
tb/lane_edge_point_tracker_test.sv
